// ===== rtl/core/bpc_pkg.sv =====
`timescale 1ns / 1ps

package bpc_pkg;

  // Restoring divider depth, one quotient bit per stage
  localparam int unsigned DivBits = 32;

  typedef enum logic [2:0] {
    REG_CAL_SIGNED_A   = 3'd0,
    REG_CAL_UNSIGNED_A = 3'd1,
    REG_CAL_B_PAIR     = 3'd2,
    REG_CAL_M_PAIR     = 3'd3,
    REG_OVERSAMPLING   = 3'd4
  } cfg_reg_e;

  localparam logic signed [31:0] B6Offset   = 32'sd4000;
  localparam logic signed [31:0] P1Coeff    = 32'sd3038;
  localparam logic signed [31:0] P2Coeff    = -32'sd7357;
  localparam logic signed [31:0] P3Coeff    = 32'sd3791;
  localparam logic signed [31:0] B4Bias     = 32'sd32768;
  localparam logic [15:0]        PressScale = 16'd50000;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] num;  // dividend bits out at the top, quotient bits in at the bottom
    logic [31:0] den;
  } div_st_t;

  // sideband that travels beside a divider; each instance uses its own fields, and both use fault
  typedef struct packed {
    logic signed [31:0] x1;
    logic               neg;
    logic               fault;
    logic [23:0]        up;
    logic signed [15:0] temp;
    logic               half;
  } div_side_t;

endpackage

// ===== rtl/core/bpc_ifs.sv =====
`timescale 1ns / 1ps

interface bpc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_temperature;
  logic [23:0] raw_pressure_bytes;
  modport source (output valid, raw_temperature, raw_pressure_bytes, input ready);
  modport sink (input valid, raw_temperature, raw_pressure_bytes, output ready);
endinterface

interface bpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temperature_tenths;
  logic signed [31:0] pressure_pa;
  logic               division_fault;
  modport source (output valid, temperature_tenths, pressure_pa, division_fault,
                  input ready);
  modport sink (input valid, temperature_tenths, pressure_pa, division_fault,
                output ready);
endinterface

interface bpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [47:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/bpc_div.sv =====
`timescale 1ns / 1ps

module bpc_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [31:0]           dividend_i,
  input  logic [31:0]           divisor_i,
  input  bpc_pkg::div_side_t    side_i,
  output logic                  valid_o,
  output logic [31:0]           quotient_o,
  output bpc_pkg::div_side_t    side_o
);

  bpc_pkg::div_st_t   st_d [bpc_pkg::DivBits];
  bpc_pkg::div_st_t   st_q [bpc_pkg::DivBits];
  logic               vld_q [bpc_pkg::DivBits];
  bpc_pkg::div_side_t side_q [bpc_pkg::DivBits];
  bpc_pkg::div_st_t   init;

  function automatic bpc_pkg::div_st_t div_step(bpc_pkg::div_st_t s);
    bpc_pkg::div_st_t r;
    logic [32:0]      trial;
    trial = {s.rem, s.num[31]};
    r.den = s.den;
    r.num = {s.num[30:0], 1'b0};
    if (trial >= {1'b0, s.den}) begin
      r.rem    = 32'(trial - {1'b0, s.den});
      r.num[0] = 1'b1;
    end else begin
      r.rem = trial[31:0];
    end
    return r;
  endfunction

  assign init = '{rem: '0, num: dividend_i, den: divisor_i};

  always_comb begin
    st_d[0] = div_step(init);
    for (int k = 1; k < bpc_pkg::DivBits; k++) begin
      st_d[k] = div_step(st_q[k-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < bpc_pkg::DivBits; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int k = 1; k < bpc_pkg::DivBits; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0]   <= st_d[0];
      side_q[0] <= side_i;
      for (int k = 1; k < bpc_pkg::DivBits; k++) begin
        st_q[k]   <= st_d[k];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign valid_o    = vld_q[bpc_pkg::DivBits-1];
  assign quotient_o = st_q[bpc_pkg::DivBits-1].num;
  assign side_o     = side_q[bpc_pkg::DivBits-1];

endmodule

// ===== rtl/core/barometric_pressure_compensation.sv =====
`timescale 1ns / 1ps

// channel  | dir | transaction
// cfg_i    | in  | index, data: calibration / oversampling register write
// in_i     | in  | raw_temperature, raw_pressure_bytes
// out_o    | out | temperature_tenths, pressure_pa, division_fault
//
// One transaction per cycle in and out unless out_o stalls. Stages: input register, 2 stages,
// 32-stage temperature divider, 6 stages, 32-stage pressure divider, 3 stages incl. output.
// Every stage advances together; the pipeline holds while out_o is stalled. Reset clears
// config and valid bits. The user must write configuration while idle; it is unchecked.

module barometric_pressure_compensation (
  input  logic clk_i,
  input  logic rst_ni,
  bpc_cfg_if.sink   cfg_i,
  bpc_in_if.sink    in_i,
  bpc_out_if.source out_o
);

  logic [47:0] cal_sa_q, cal_ua_q;
  logic [31:0] cal_b_q, cal_m_q;
  logic [1:0]  oss_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_sa_q <= '0;
      cal_ua_q <= '0;
      cal_b_q  <= '0;
      cal_m_q  <= '0;
      oss_q    <= '0;
    end else if (cfg_i.valid) begin
      case (bpc_pkg::cfg_reg_e'(cfg_i.index))
        bpc_pkg::REG_CAL_SIGNED_A:   cal_sa_q <= cfg_i.data;
        bpc_pkg::REG_CAL_UNSIGNED_A: cal_ua_q <= cfg_i.data;
        bpc_pkg::REG_CAL_B_PAIR:     cal_b_q  <= cfg_i.data[31:0];
        bpc_pkg::REG_CAL_M_PAIR:     cal_m_q  <= cfg_i.data[31:0];
        bpc_pkg::REG_OVERSAMPLING:   oss_q    <= cfg_i.data[1:0];
        default: ;
      endcase
    end
  end

  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [15:0] ac4, ac5, ac6;
  assign ac1 = $signed(cal_sa_q[47:32]);
  assign ac2 = $signed(cal_sa_q[31:16]);
  assign ac3 = $signed(cal_sa_q[15:0]);
  assign ac4 = cal_ua_q[47:32];
  assign ac5 = cal_ua_q[31:16];
  assign ac6 = cal_ua_q[15:0];
  assign b1  = $signed(cal_b_q[31:16]);
  assign b2  = $signed(cal_b_q[15:0]);
  assign mc  = $signed(cal_m_q[31:16]);
  assign md  = $signed(cal_m_q[15:0]);

  logic pipe_en;
  logic k_vld_q;
  assign pipe_en    = !k_vld_q || out_o.ready;
  assign in_i.ready = pipe_en;

  // ---- stage registers
  logic s0_vld_q, a_vld_q, b_vld_q, c_vld_q, d_vld_q, e_vld_q, f_vld_q, g_vld_q, h_vld_q;
  logic i_vld_q, j_vld_q;
  logic div1_vld, div2_vld;

  logic [15:0] s0_ut_q;
  logic [23:0] s0_up_q, a_up_q;
  logic signed [31:0] a_x1_q;
  logic [31:0] b_num_q, b_den_q;
  bpc_pkg::div_side_t b_side_q, div1_side, h_side_q, div2_side;
  logic [31:0] div1_q, div2_q;
  logic signed [31:0] c_b5_q;
  logic [23:0] c_up_q, d_up_q, e_up_q, f_up_q;
  logic c_fault_q, d_fault_q, e_fault_q, f_fault_q, g_fault_q, i_fault_q, j_fault_q;
  logic signed [15:0] d_t_q, e_t_q, f_t_q, g_t_q, i_t_q, j_t_q;
  logic signed [31:0] d_sq_q, d_x2a_q, d_x1c_q;
  logic signed [31:0] e_x1_q, e_x2_q, e_x2a_q, e_x1c_q;
  logic signed [31:0] f_b3_q, f_t4_q;
  logic [31:0] g_b4_q, g_b7_q;
  logic [31:0] h_num_q, h_den_q;
  logic signed [31:0] i_p_q, i_x1sq_q, i_x2_q;
  logic signed [31:0] j_p_q, j_x1_q, j_x2_q;
  logic signed [15:0] k_t_q;
  logic signed [31:0] k_p_q;
  logic k_fault_q;

  // ---- combinational stage logic
  logic [23:0] s0_up_d;
  logic signed [16:0] a_diff;
  logic signed [33:0] a_prod;
  logic signed [31:0] a_x1_d;
  logic signed [31:0] b_x3, b_numv;
  bpc_pkg::div_side_t b_side_d;
  logic signed [31:0] c_x2, c_b5_d;
  logic signed [31:0] d_tsum, d_b6;
  logic signed [15:0] d_t_d;
  logic signed [63:0] d_p0;
  logic signed [47:0] d_p1, d_p2, e_p0, e_p1;
  logic signed [31:0] f_s, f_sh, f_v, f_b3_d, f_x3, f_t4_d;
  logic [47:0] g_p0, g_p1;
  logic [31:0] g_diff;
  logic [15:0] g_scale;
  bpc_pkg::div_side_t h_side_d;
  logic [31:0] i_pu;
  logic signed [31:0] i_p, i_ps;
  logic signed [63:0] i_p0, i_p1, j_p0;
  logic signed [31:0] k_p_d;

  always_comb begin
    s0_up_d = in_i.raw_pressure_bytes >> (4'd8 - {2'b00, oss_q});

    a_diff = $signed({1'b0, s0_ut_q}) - $signed({1'b0, ac6});
    a_prod = a_diff * $signed({1'b0, ac5});
    a_x1_d = $signed(a_prod[31:0]) >>> 15;

    b_x3  = a_x1_q + md;
    b_numv = {{5{mc[15]}}, mc, 11'b0};
    b_side_d       = '0;
    b_side_d.x1    = a_x1_q;
    b_side_d.neg   = mc[15] ^ b_x3[31];
    b_side_d.fault = (b_x3 == 32'sd0);
    b_side_d.up    = a_up_q;

    c_x2   = div1_side.neg ? -$signed(div1_q) : $signed(div1_q);
    c_b5_d = div1_side.x1 + c_x2;

    d_tsum = (c_b5_q + 32'sd8) >>> 4;
    if (d_tsum > 32'sd32767)       d_t_d = 16'sh7fff;
    else if (d_tsum < -32'sd32768) d_t_d = -16'sh8000;
    else                           d_t_d = d_tsum[15:0];
    d_b6 = c_b5_q - bpc_pkg::B6Offset;
    d_p0 = d_b6 * d_b6;
    d_p1 = ac2 * d_b6;
    d_p2 = ac3 * d_b6;

    e_p0 = b2 * d_sq_q;
    e_p1 = b1 * d_sq_q;

    f_s    = {{14{ac1[15]}}, ac1, 2'b00} + e_x1_q + e_x2a_q;
    f_sh   = f_s << oss_q;
    f_v    = f_sh + 32'sd2;
    f_b3_d = (f_v + (f_v[31] ? 32'sd3 : 32'sd0)) >>> 2;
    f_x3   = (e_x1c_q + e_x2_q + 32'sd2) >>> 2;
    f_t4_d = f_x3 + bpc_pkg::B4Bias;

    g_p0    = ac4 * $unsigned(f_t4_q);
    g_scale = bpc_pkg::PressScale >> oss_q;
    g_diff  = {8'b0, f_up_q} - $unsigned(f_b3_q);
    g_p1    = g_diff * g_scale;

    h_side_d       = '0;
    h_side_d.fault = g_fault_q || (g_b4_q == 32'd0);
    h_side_d.temp  = g_t_q;
    h_side_d.half  = g_b7_q[31];

    i_pu = div2_side.half ? {div2_q[30:0], 1'b0} : div2_q;
    i_p  = $signed(i_pu);
    i_ps = i_p >>> 8;
    i_p0 = i_ps * i_ps;
    i_p1 = bpc_pkg::P2Coeff * i_p;

    j_p0 = i_x1sq_q * bpc_pkg::P1Coeff;

    k_p_d = j_p_q + ((j_x1_q + j_x2_q + bpc_pkg::P3Coeff) >>> 4);
  end

  bpc_div u_div_temp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (pipe_en),
    .valid_i    (b_vld_q),
    .dividend_i (b_num_q),
    .divisor_i  (b_den_q),
    .side_i     (b_side_q),
    .valid_o    (div1_vld),
    .quotient_o (div1_q),
    .side_o     (div1_side)
  );

  bpc_div u_div_press (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (pipe_en),
    .valid_i    (h_vld_q),
    .dividend_i (h_num_q),
    .divisor_i  (h_den_q),
    .side_i     (h_side_q),
    .valid_o    (div2_vld),
    .quotient_o (div2_q),
    .side_o     (div2_side)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
      a_vld_q  <= 1'b0;
      b_vld_q  <= 1'b0;
      c_vld_q  <= 1'b0;
      d_vld_q  <= 1'b0;
      e_vld_q  <= 1'b0;
      f_vld_q  <= 1'b0;
      g_vld_q  <= 1'b0;
      h_vld_q  <= 1'b0;
      i_vld_q  <= 1'b0;
      j_vld_q  <= 1'b0;
      k_vld_q  <= 1'b0;
    end else if (pipe_en) begin
      s0_vld_q <= in_i.valid;
      a_vld_q  <= s0_vld_q;
      b_vld_q  <= a_vld_q;
      c_vld_q  <= div1_vld;
      d_vld_q  <= c_vld_q;
      e_vld_q  <= d_vld_q;
      f_vld_q  <= e_vld_q;
      g_vld_q  <= f_vld_q;
      h_vld_q  <= g_vld_q;
      i_vld_q  <= div2_vld;
      j_vld_q  <= i_vld_q;
      k_vld_q  <= j_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s0_ut_q <= in_i.raw_temperature;
      s0_up_q <= s0_up_d;

      a_x1_q <= a_x1_d;
      a_up_q <= s0_up_q;

      b_num_q  <= b_numv[31] ? $unsigned(-b_numv) : $unsigned(b_numv);
      b_den_q  <= b_x3[31] ? $unsigned(-b_x3) : $unsigned(b_x3);
      b_side_q <= b_side_d;

      c_b5_q    <= c_b5_d;
      c_up_q    <= div1_side.up;
      c_fault_q <= div1_side.fault;

      d_t_q     <= d_t_d;
      d_sq_q    <= $signed(d_p0[31:0]) >>> 12;
      d_x2a_q   <= $signed(d_p1[31:0]) >>> 11;
      d_x1c_q   <= $signed(d_p2[31:0]) >>> 13;
      d_up_q    <= c_up_q;
      d_fault_q <= c_fault_q;

      e_x1_q    <= $signed(e_p0[31:0]) >>> 11;
      e_x2_q    <= $signed(e_p1[31:0]) >>> 16;
      e_x2a_q   <= d_x2a_q;
      e_x1c_q   <= d_x1c_q;
      e_t_q     <= d_t_q;
      e_up_q    <= d_up_q;
      e_fault_q <= d_fault_q;

      f_b3_q    <= f_b3_d;
      f_t4_q    <= f_t4_d;
      f_t_q     <= e_t_q;
      f_up_q    <= e_up_q;
      f_fault_q <= e_fault_q;

      g_b4_q    <= {15'b0, g_p0[31:15]};
      g_b7_q    <= g_p1[31:0];
      g_t_q     <= f_t_q;
      g_fault_q <= f_fault_q;

      // B7 at or above 2^31 divides first, then doubles
      h_num_q  <= g_b7_q[31] ? g_b7_q : {g_b7_q[30:0], 1'b0};
      h_den_q  <= g_b4_q;
      h_side_q <= h_side_d;

      i_p_q     <= i_p;
      i_x1sq_q  <= i_p0[31:0];
      i_x2_q    <= $signed(i_p1[31:0]) >>> 16;
      i_t_q     <= div2_side.temp;
      i_fault_q <= div2_side.fault;

      j_x1_q    <= $signed(j_p0[31:0]) >>> 16;
      j_x2_q    <= i_x2_q;
      j_p_q     <= i_p_q;
      j_t_q     <= i_t_q;
      j_fault_q <= i_fault_q;

      k_t_q     <= j_fault_q ? 16'sd0 : j_t_q;
      k_p_q     <= j_fault_q ? 32'sd0 : k_p_d;
      k_fault_q <= j_fault_q;
    end
  end

  assign out_o.valid              = k_vld_q;
  assign out_o.temperature_tenths = k_t_q;
  assign out_o.pressure_pa        = k_p_q;
  assign out_o.division_fault     = k_fault_q;

  // a fault result carries zeros
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.division_fault |-> out_o.temperature_tenths == 16'sd0 &&
      out_o.pressure_pa == 32'sd0)
    else $error("fault result not zeroed");

  // a stall freezes the valid bits of stages s0, b and k
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(s0_vld_q) && $stable(b_vld_q) && $stable(k_vld_q))
    else $error("pipeline moved during stall");

  // an accepted transaction reaches the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> s0_vld_q)
    else $error("accepted transaction lost at input stage");

endmodule
